/* hw/rtl/brightness_contrast_pixel_core_defines.svh */
// assertion macros shared by the brightness/contrast pixel core
// no dependencies; included by files that carry concurrent checks
`ifndef BRIGHTNESS_CONTRAST_PIXEL_CORE_DEFINES_SVH
`define BRIGHTNESS_CONTRAST_PIXEL_CORE_DEFINES_SVH

// antecedent implies consequent on the same edge, off while in reset
`define BCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition must never be seen, off while in reset
`define BCP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `BCP_ASSERT_IMP(lbl, clk, rstn, 1'b1, !(cond), msg)

`endif

/* hw/rtl/bcp_pkg.sv */
// shared widths, constants and types of the brightness/contrast pixel core
// no dependencies; imported by every module of the block
`default_nettype none

package bcp_pkg;

    // channel and lane layout
    localparam int CH_W  = 8;
    localparam int LANES = 3;
    localparam int PIX_W = 32;

    // arithmetic widths
    localparam int T_W   = 10;  // v - 128 + b
    localparam int K_W   = 17;  // 259 * (c + 255)
    localparam int DEN_W = 17;  // 255 * (259 - c)
    localparam int OFF_W = 24;  // 128 * 255 * (259 - c)
    localparam int NUM_W = 27;  // signed numerator
    localparam int REM_W = 25;  // remainder below den << 8

    // formula constants
    localparam int GAIN_MUL = 259;
    localparam int DEN_MUL  = 255;
    localparam int MID      = 128;
    localparam int OFF_MUL  = MID * DEN_MUL;
    localparam int C_BIAS   = 255;

    localparam logic signed [CH_W-1:0] CONTRAST_MIN = -8'sd100;
    localparam logic signed [CH_W-1:0] CONTRAST_MAX = 8'sd100;

    // pipeline shape: input stage, product, numerator, one stage per quotient bit
    localparam int PRE_STAGES = 2;
    localparam int DIV_STAGES = CH_W;
    localparam int PIPE_DEPTH = 1 + PRE_STAGES + DIV_STAGES;
    localparam int RESULT_LAT = PIPE_DEPTH + 1;

    // coefficients derived from the contrast register
    typedef struct packed {
        logic [K_W-1:0]   k;
        logic [OFF_W-1:0] off;
        logic [DEN_W-1:0] den;
    } t_coef;

    // per-request control travelling to the merge stage
    typedef struct packed {
        logic vld;
        logic byp;
    } t_ctrl;

endpackage

`default_nettype wire

/* hw/rtl/bcp_lane.sv */
// one colour channel lane: scaled numerator and a pipelined restoring divider
// depends on bcp_pkg
`default_nettype none

module bcp_lane import bcp_pkg::*; (
    input  logic            i_clk,
    input  logic [CH_W-1:0] i_chan,
    input  logic [CH_W-1:0] i_bright,
    input  t_coef           i_coef,
    output logic [CH_W-1:0] o_chan
);

    logic signed [T_W-1:0]   w_t;
    logic signed [NUM_W-1:0] w_t_ext;
    logic signed [NUM_W-1:0] w_k_ext;
    logic signed [NUM_W-1:0] w_prod;
    logic signed [NUM_W-1:0] r_prod;
    logic signed [NUM_W-1:0] w_num;
    logic [NUM_W-1:0]        w_lim;
    logic                    w_neg;
    logic                    w_sat;

    logic [REM_W-1:0] r_rem [DIV_STAGES];
    logic [CH_W-1:0]  r_q   [DIV_STAGES+1];
    logic             r_neg [DIV_STAGES+1];
    logic             r_sat [DIV_STAGES+1];

    // offset channel value and form k * t
    assign w_t = $signed({{(T_W-CH_W){1'b0}}, i_chan})
               + $signed({{(T_W-CH_W){i_bright[CH_W-1]}}, i_bright})
               - $signed(T_W'(MID));
    assign w_t_ext = $signed({{(NUM_W-T_W){w_t[T_W-1]}}, w_t});
    assign w_k_ext = $signed({{(NUM_W-K_W){1'b0}}, i_coef.k});
    assign w_prod  = w_k_ext * w_t_ext;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // numerator, sign and overflow of the quotient
    assign w_num = r_prod + $signed({{(NUM_W-OFF_W){1'b0}}, i_coef.off});
    assign w_lim = NUM_W'({i_coef.den, {CH_W{1'b0}}});
    assign w_neg = w_num[NUM_W-1];
    assign w_sat = !w_neg && ($unsigned(w_num) >= w_lim);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_num[REM_W-1:0];
        r_q[0]   <= '0;
        r_neg[0] <= w_neg;
        r_sat[0] <= w_sat;
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        localparam int SH = CH_W - 1 - j;
        logic [REM_W-1:0] w_dsh;
        logic             w_ge;

        assign w_dsh = REM_W'(i_coef.den) << SH;
        assign w_ge  = r_rem[j] >= w_dsh;

        always_ff @(posedge i_clk) begin
            r_q[j+1]   <= r_q[j] | (CH_W'(w_ge) << SH);
            r_neg[j+1] <= r_neg[j];
            r_sat[j+1] <= r_sat[j];
        end

        if (j < DIV_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[j+1] <= w_ge ? (r_rem[j] - w_dsh) : r_rem[j];
            end
        end
    end

    // clamp to the channel range
    assign o_chan = r_neg[DIV_STAGES] ? '0
                  : (r_sat[DIV_STAGES] ? '1 : r_q[DIV_STAGES]);

endmodule

`default_nettype wire

/* hw/rtl/bcp_merge.sv */
// merge stage: reassembles the pixel from the lanes or passes it through
// depends on bcp_pkg
`default_nettype none

module bcp_merge import bcp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctrl                      i_ctrl,
    input  logic [PIX_W-1:0]           i_pixel,
    input  logic [LANES-1:0][CH_W-1:0] i_chan,
    output logic                       o_done,
    output logic [PIX_W-1:0]           o_pixel
);

    logic             r_done;
    logic [PIX_W-1:0] r_pixel;
    logic [PIX_W-1:0] n_pixel;

    // alpha kept, colour channels from the lanes unless bypassed
    assign n_pixel = i_ctrl.byp ? i_pixel
                   : {i_pixel[PIX_W-1:LANES*CH_W], i_chan};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctrl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= n_pixel;
    end

    assign o_done  = r_done;
    assign o_pixel = r_pixel;

endmodule

`default_nettype wire

/* hw/rtl/brightness_contrast_pixel_core.sv */
// top level of the brightness/contrast pixel core: config registers,
// request pipeline, three channel lanes and the merge stage
// depends on bcp_pkg, bcp_lane, bcp_merge and the defines header
//
// usage
//   configuration: APB-style port, brightness at byte address 0, contrast at
//   address 4, low 8 bits of pwdata used, pready always high; write only
//   while no request is in flight
//   requests: a pixel and its selected flag are taken at each rising edge
//   with start high and busy low; busy stays low, so one request per clock
//   results: o_done marks o_pixel_out for one cycle, in request order, once
//   the request has passed through the whole pipeline and the merge register
//   the depth is set by the eight stage restoring divider in each lane,
//   plus input, product, numerator and merge registers
//   the receiver cannot stall; a result is shown once and then dropped
//   reset clears both registers to zero and empties the pipeline
`default_nettype none
`include "brightness_contrast_pixel_core_defines.svh"

module brightness_contrast_pixel_core import bcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             start,
    output logic             busy,
    input  logic [PIX_W-1:0] i_pixel_in,
    input  logic             i_selected,
    output logic             o_done,
    output logic [PIX_W-1:0] o_pixel_out
);

    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_CONTRAST   = 1'b1;

    logic [CH_W-1:0]  r_brightness;
    logic [CH_W-1:0]  r_contrast;
    t_coef            r_coef;
    logic             w_wr;
    logic             w_take;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] r_byp;
    logic [PIX_W-1:0]      r_pix [PIPE_DEPTH];

    logic [LANES-1:0][CH_W-1:0] w_chan;
    t_ctrl                      w_ctrl;

    // clamp contrast and derive gain, offset and divisor
    function automatic t_coef coef_of(input logic [CH_W-1:0] c);
        logic signed [CH_W-1:0] cs;
        logic signed [CH_W-1:0] cc;
        logic signed [9:0]      cw;
        logic [8:0]             cp;
        logic [8:0]             cm;
        t_coef                  res;
        cs = $signed(c);
        if (cs < CONTRAST_MIN) begin
            cc = CONTRAST_MIN;
        end else if (cs > CONTRAST_MAX) begin
            cc = CONTRAST_MAX;
        end else begin
            cc = cs;
        end
        cw = {{2{cc[CH_W-1]}}, cc};
        cp = 9'(cw + 10'(C_BIAS));
        cm = 9'(10'(GAIN_MUL) - cw);
        res.k   = K_W'(cp) * K_W'(GAIN_MUL);
        res.den = DEN_W'(cm) * DEN_W'(DEN_MUL);
        res.off = OFF_W'(cm) * OFF_W'(OFF_MUL);
        return res;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CONTRAST) ? {24'b0, r_contrast}
                                              : {24'b0, r_brightness};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= '0;
            r_contrast   <= '0;
        end else if (w_wr) begin
            if (paddr[2] == REG_BRIGHTNESS) begin
                r_brightness <= pwdata[CH_W-1:0];
            end else begin
                r_contrast <= pwdata[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= coef_of(r_contrast);
    end

    // request pipeline: valid, bypass and pixel follow the lanes
    assign busy   = 1'b0;
    assign w_take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_take};
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp    <= {r_byp[PIPE_DEPTH-2:0],
                     !i_selected || (i_pixel_in[PIX_W-1:LANES*CH_W] == '0)};
        r_pix[0] <= i_pixel_in;
        for (int s = 1; s < PIPE_DEPTH; s++) begin
            r_pix[s] <= r_pix[s-1];
        end
    end

    // colour lanes, blue in lane 0
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        bcp_lane u_lane (
            .i_clk    (i_clk),
            .i_chan   (r_pix[0][l*CH_W +: CH_W]),
            .i_bright (r_brightness),
            .i_coef   (r_coef),
            .o_chan   (w_chan[l])
        );
    end

    assign w_ctrl.vld = r_vld[PIPE_DEPTH-1];
    assign w_ctrl.byp = r_byp[PIPE_DEPTH-1];

    bcp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_pixel (r_pix[PIPE_DEPTH-1]),
        .i_chan  (w_chan),
        .o_done  (o_done),
        .o_pixel (o_pixel_out)
    );

    // checks
    `BCP_ASSERT_IMP(a_done_has_request, i_clk, i_rst_n, o_done,
        $past(start && !busy, RESULT_LAT), "result without a matching request")
    `BCP_ASSERT_IMP(a_alpha_kept, i_clk, i_rst_n, o_done,
        o_pixel_out[31:24] == $past(i_pixel_in[31:24], RESULT_LAT),
        "alpha changed")
    `BCP_ASSERT_NEVER(a_bypass_exact, i_clk, i_rst_n,
        o_done && $past(!i_selected || i_pixel_in[31:24] == 8'h00, RESULT_LAT)
        && (o_pixel_out != $past(i_pixel_in, RESULT_LAT)),
        "bypassed pixel altered")

endmodule

`default_nettype wire
